@@ hw/rtl/wbps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int WORD_BYTES  = 8;
    localparam int NUM_WORDS   = MAX_PATTERN / WORD_BYTES;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_IS_WILDCARD = 3'd6;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] byte_offset;
        logic        section_first;
        logic        scan_first;
        logic        scan_last;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
    } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/wildcard_byte_pattern_scan_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted input is held in the input register; its result, if any, is registered when it advances.
// Throughput: one byte per cycle unless the output stalls; an input register and a result register
// are joined by a single masked compare of the window against the pattern.
// Reset (aresetn low, synchronous): pipeline empty, window and section count
// cleared, scan not done, pattern_length 1 and the other configuration registers 0.

module wildcard_byte_pattern_scan_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire wbps_pkg::in_item_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output wbps_pkg::out_item_t                    m_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import wbps_pkg::*;

    // configuration
    logic [LEN_W-1:0]       pattern_length_reg;
    logic [CFG_DATA_W-1:0]  pattern_word_reg [NUM_WORDS];
    logic [MAX_PATTERN-1:0] wildcard_mask_reg;
    logic                   zero_wild_reg;

    // pattern aligned to window age
    logic [MAX_PATTERN-1:0] care_reg, care_next;
    logic [7:0]             want_reg [MAX_PATTERN];
    logic [7:0]             want_next [MAX_PATTERN];
    logic [LEN_W-1:0]       len_reg, len_next;

    // datapath
    logic                   in_valid_reg;
    in_item_t               in_item_reg;
    logic [7:0]             window_reg [MAX_PATTERN-1];
    logic [LEN_W-1:0]       count_reg, count_next;
    logic                   done_reg, done_next;
    logic                   m_valid_reg;
    out_item_t              m_data_reg, m_data_next;

    logic [7:0]             pat_bytes [MAX_PATTERN];
    logic [7:0]             recent [MAX_PATTERN];
    logic                   advance;
    logic                   sec_start;
    logic                   done_eff;
    logic                   match;
    logic                   has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LEN_W'(1);
            for (int w = 0; w < NUM_WORDS; w++) begin
                pattern_word_reg[w] <= '0;
            end
            wildcard_mask_reg <= '0;
            zero_wild_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_LENGTH:   pattern_length_reg <= cfg_wdata[LEN_W-1:0];
                REG_PATTERN_WORD_0:   pattern_word_reg[0] <= cfg_wdata;
                REG_PATTERN_WORD_1:   pattern_word_reg[1] <= cfg_wdata;
                REG_PATTERN_WORD_2:   pattern_word_reg[2] <= cfg_wdata;
                REG_PATTERN_WORD_3:   pattern_word_reg[3] <= cfg_wdata;
                REG_WILDCARD_MASK:    wildcard_mask_reg <= cfg_wdata[MAX_PATTERN-1:0];
                REG_ZERO_IS_WILDCARD: zero_wild_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [LEN_W-1:0] idx;
        if (pattern_length_reg == '0) begin
            len_next = LEN_W'(1);
        end else if (pattern_length_reg > LEN_W'(MAX_PATTERN)) begin
            len_next = LEN_W'(MAX_PATTERN);
        end else begin
            len_next = pattern_length_reg;
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pat_bytes[j] = pattern_word_reg[j / WORD_BYTES][(j % WORD_BYTES) * 8 +: 8];
        end
        // want[k] is the pattern byte compared with the byte k steps ago
        for (int k = 0; k < MAX_PATTERN; k++) begin
            idx          = len_next - LEN_W'(k) - LEN_W'(1);
            want_next[k] = pat_bytes[idx[IDX_W-1:0]];
            care_next[k] = (LEN_W'(k) < len_next)
                && !wildcard_mask_reg[idx[IDX_W-1:0]]
                && !(zero_wild_reg && (pat_bytes[idx[IDX_W-1:0]] == 8'h00));
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        care_reg <= care_next;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            want_reg[k] <= want_next[k];
        end
    end

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        sec_start = in_item_reg.section_first || in_item_reg.scan_first;
        done_eff  = done_reg && !in_item_reg.scan_first;

        recent[0] = in_item_reg.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            recent[k] = sec_start ? 8'h00 : window_reg[k-1];
        end

        count_next = sec_start ? LEN_W'(1)
                   : (count_reg == LEN_W'(MAX_PATTERN)) ? count_reg
                   : count_reg + LEN_W'(1);

        match = (count_next >= len_reg);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (care_reg[k] && (recent[k] != want_reg[k])) begin
                match = 1'b0;
            end
        end

        has_result = !done_eff && (match || in_item_reg.scan_last);
        done_next  = done_eff || match || in_item_reg.scan_last;

        m_data_next.found        = match;
        m_data_next.match_offset = match
            ? in_item_reg.byte_offset - {{(32-LEN_W){1'b0}}, len_reg - LEN_W'(1)}
            : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            for (int k = 0; k < MAX_PATTERN - 1; k++) begin
                window_reg[k] <= 8'h00;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= has_result;
                count_reg   <= count_next;
                done_reg    <= done_next;
                for (int k = 0; k < MAX_PATTERN - 1; k++) begin
                    window_reg[k] <= recent[k];
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
        if (advance && has_result) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ verif/scan_check_pkg.sv @@
`timescale 1ns / 1ps

package scan_check_pkg;
    import wbps_pkg::*;

    class match_predictor;
        logic [5:0]  pat_len;
        logic [63:0] pat_word [NUM_WORDS];
        logic [31:0] wild_mask;
        logic        zero_wild;
        logic [7:0]  history [MAX_PATTERN-1];
        int          sec_count;
        bit          scan_over;
        out_item_t   expected_hits [$];
        int unsigned mismatches;

        function new();
            pat_len = 6'd1;
            foreach (pat_word[i]) pat_word[i] = '0;
            wild_mask = '0;
            zero_wild = 1'b0;
            foreach (history[i]) history[i] = '0;
            sec_count = 0;
            scan_over = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PATTERN_LENGTH:   pat_len = value[5:0];
                REG_PATTERN_WORD_0:   pat_word[0] = value;
                REG_PATTERN_WORD_1:   pat_word[1] = value;
                REG_PATTERN_WORD_2:   pat_word[2] = value;
                REG_PATTERN_WORD_3:   pat_word[3] = value;
                REG_WILDCARD_MASK:    wild_mask = value[31:0];
                REG_ZERO_IS_WILDCARD: zero_wild = value[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_byte(int j);
            return pat_word[j / WORD_BYTES][(j % WORD_BYTES) * 8 +: 8];
        endfunction

        function int eff_len();
            if (pat_len == 0) return 1;
            if (pat_len > MAX_PATTERN) return MAX_PATTERN;
            return int'(pat_len);
        endfunction

        function void queue_result(out_item_t r);
            expected_hits.insert(expected_hits.size(), r);
        endfunction

        function void note_byte(in_item_t item);
            logic [7:0] recent [MAX_PATTERN];
            logic [7:0] p;
            int         len;
            bit         hit;
            bit         sec_start;
            bit         wild;
            out_item_t  res;
            len = eff_len();
            sec_start = item.section_first;
            if (item.scan_first) begin
                scan_over = 1'b0;
                sec_start = 1'b1;
            end
            if (sec_start) begin
                foreach (history[i]) history[i] = '0;
                sec_count = 0;
            end
            recent[0] = item.data_byte;
            for (int i = 1; i < MAX_PATTERN; i++) recent[i] = history[i-1];
            if (sec_count < MAX_PATTERN) sec_count++;
            hit = (sec_count >= len);
            for (int i = 0; i < len; i++) begin
                p = pattern_byte(i);
                wild = wild_mask[i] || (zero_wild && p == 8'h00);
                if (!wild && p != recent[len-1-i]) hit = 1'b0;
            end
            for (int i = MAX_PATTERN - 2; i > 0; i--) history[i] = history[i-1];
            history[0] = item.data_byte;
            if (scan_over) return;
            if (hit) begin
                scan_over = 1'b1;
                res.found = 1'b1;
                res.match_offset = item.byte_offset - 32'(len - 1);
                queue_result(res);
            end else if (item.scan_last) begin
                scan_over = 1'b1;
                res.found = 1'b0;
                res.match_offset = '0;
                queue_result(res);
            end
        endfunction

        function void flag(string what, out_item_t want, out_item_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected found=%0b offset=%h, got found=%0b offset=%h",
                         what, want.found, want.match_offset, got.found, got.match_offset);
        endfunction

        function void check_hit(out_item_t got);
            out_item_t want;
            if (expected_hits.size() == 0) begin
                flag("unexpected transaction", '0, got);
                return;
            end
            want = expected_hits.pop_front();
            if (got.found !== want.found || got.match_offset !== want.match_offset)
                flag("result mismatch", want, got);
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import wbps_pkg::*;
    import scan_check_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASE_ITEMS  = 60;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    match_predictor model;
    in_item_t       stim_q [$];
    bit             tx_bursty;
    bit             rx_free;
    int             pause_at;
    int             idle_cycles = 0;
    int             random_sent;
    int             phase;
    int             rx_run = 0;
    bit             rx_on = 1'b0;

    wildcard_byte_pattern_scan_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) model.write_reg(cfg_index, cfg_wdata);
            if (s_valid && s_ready) model.note_byte(s_data);
            if (m_valid && m_ready) model.check_hit(m_data);
            if (cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("wildcard_byte_pattern_scan_core regression: fail");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_run == 0) begin
            rx_on = !rx_on;
            rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        rx_run--;
        m_ready <= rx_free || rx_on;
    end

    function automatic in_item_t mk(logic [7:0] d, logic [31:0] o, logic sf, logic scf,
                                    logic sl);
        in_item_t it;
        it.data_byte = d;
        it.byte_offset = o;
        it.section_first = sf;
        it.scan_first = scf;
        it.scan_last = sl;
        return it;
    endfunction

    function automatic void queue_stim(in_item_t it);
        stim_q.insert(stim_q.size(), it);
    endfunction

    task automatic settle();
        while (model.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    task automatic load_config(logic [5:0] len, logic [63:0] w0, logic [63:0] w1,
                               logic [63:0] w2, logic [63:0] w3, logic [31:0] mask,
                               logic zw);
        settle();
        cfg_write(REG_PATTERN_LENGTH, 64'(len));
        cfg_write(REG_PATTERN_WORD_0, w0);
        cfg_write(REG_PATTERN_WORD_1, w1);
        cfg_write(REG_PATTERN_WORD_2, w2);
        cfg_write(REG_PATTERN_WORD_3, w3);
        cfg_write(REG_WILDCARD_MASK, 64'(mask));
        cfg_write(REG_ZERO_IS_WILDCARD, 64'(zw));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_all();
        in_item_t it;
        int       burst_left;
        int       gap;
        int       n;
        burst_left = $urandom_range(1, 40);
        n = 0;
        while (stim_q.size() != 0) begin
            it = stim_q.pop_front();
            if (n == pause_at) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (model.pending() != 0) @(posedge aclk);
            end else if (tx_bursty && burst_left == 0) begin
                gap = $urandom_range(1, 6);
                repeat (gap) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 40);
            end
            @(negedge aclk);
            s_valid <= 1'b1;
            s_data <= it;
            do @(posedge aclk); while (!s_ready);
            if (burst_left > 0) burst_left--;
            n++;
        end
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // one scan: consecutive offsets, occasional section breaks, maybe a planted pattern
    function automatic void add_scan();
        in_item_t    it;
        int          len;
        int          span;
        int          plant_at;
        int          j;
        logic [7:0]  pb;
        logic [31:0] off;
        len = model.eff_len();
        span = $urandom_range(1, 2 * len + 8);
        plant_at = ($urandom_range(0, 2) != 0) ? $urandom_range(0, span - 1) : -1;
        off = $urandom;
        for (int k = 0; k < span; k++) begin
            it.scan_first = (k == 0);
            it.section_first = (k == 0) ? 1'($urandom_range(0, 1))
                                        : ($urandom_range(0, 24) == 0);
            if (it.section_first && k != 0) off = $urandom;
            it.byte_offset = off;
            off++;
            it.data_byte = 8'($urandom);
            if (plant_at >= 0 && k >= plant_at && k < plant_at + len) begin
                j = k - plant_at;
                pb = model.pattern_byte(j);
                if (!(model.wild_mask[j] || (model.zero_wild && pb == 8'h00)))
                    it.data_byte = pb;
            end
            it.scan_last = (k == span - 1) && ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 24) == 0) begin
                it.byte_offset = $urandom;
                it.section_first = 1'($urandom_range(0, 1));
                it.scan_first = 1'($urandom_range(0, 1));
                it.scan_last = 1'($urandom_range(0, 1));
            end
            queue_stim(it);
        end
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [5:0]  len;
        logic [31:0] mask;
        model = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        tx_bursty = 1'b1;
        rx_free = 1'b0;
        pause_at = -1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset config, last byte before any scan_first, match on last byte, wrap
        queue_stim(mk(8'hFF, 32'h0, 1'b0, 1'b0, 1'b1));
        queue_stim(mk(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1));
        queue_stim(mk(8'hAA, 32'h0, 1'b0, 1'b1, 1'b1));
        send_all();

        // masked byte, section break inside a candidate, offset wrap
        load_config(6'd4, 64'h44332211, '0, '0, '0, 32'h2, 1'b0);
        queue_stim(mk(8'h11, 32'd5, 1'b0, 1'b1, 1'b0));
        queue_stim(mk(8'h99, 32'd6, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h33, 32'd7, 1'b1, 1'b0, 1'b0));
        queue_stim(mk(8'h44, 32'd8, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h11, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h55, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h33, 32'h0, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h44, 32'h1, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h11, 32'h2, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h22, 32'h3, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h33, 32'h4, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'h44, 32'h5, 1'b0, 1'b0, 1'b1));
        queue_stim(mk(8'h00, 32'h0, 1'b0, 1'b1, 1'b1));
        send_all();

        // zero length, zero byte as wildcard
        load_config(6'd0, '0, '0, '0, '0, '0, 1'b1);
        queue_stim(mk(8'hFF, 32'h1234, 1'b0, 1'b1, 1'b0));
        queue_stim(mk(8'h5A, 32'h1235, 1'b0, 1'b0, 1'b1));
        send_all();

        // oversize length, scan too short to match
        load_config(6'd63, '1, '1, '1, '1, '1, 1'b0);
        queue_stim(mk(8'hFF, 32'h0, 1'b0, 1'b1, 1'b0));
        queue_stim(mk(8'h00, 32'h1, 1'b0, 1'b0, 1'b0));
        queue_stim(mk(8'hFF, 32'h2, 1'b0, 1'b0, 1'b1));
        send_all();

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = 6'd0;
                1: len = 6'd32;
                2: len = 6'($urandom_range(33, 63));
                3: len = 6'd1;
                default: len = 6'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 4))
                0: mask = '0;
                1: mask = '1;
                2: mask = $urandom;
                default: mask = $urandom & $urandom & $urandom;
            endcase
            load_config(len, pick_word(), pick_word(), pick_word(), pick_word(), mask,
                        1'($urandom_range(0, 1)));
            tx_bursty = ($urandom_range(0, 3) != 0);
            rx_free = ($urandom_range(0, 3) == 0);
            while (stim_q.size() < PHASE_ITEMS) add_scan();
            if (phase == 2) pause_at = stim_q.size() / 2;
            else if ($urandom_range(0, 4) == 0) pause_at = $urandom_range(0, stim_q.size() - 1);
            else pause_at = -1;
            random_sent += stim_q.size();
            send_all();
            phase++;
        end

        settle();
        if (model.pending() == 0 && model.mismatches == 0) begin
            $display("wildcard_byte_pattern_scan_core regression: pass");
        end else begin
            $display("wildcard_byte_pattern_scan_core regression: fail");
        end
        $finish;
    end

endmodule
